// ===== hw/rtl/prpsc_pkg.sv =====
`timescale 1ns / 1ps
package prpsc_pkg;

	localparam int SCREEN_W = 512;
	localparam int SCREEN_H = 512;

	localparam int PIX_W = 9;
	localparam int D_W   = 14;
	localparam int SQ_W  = 28;
	localparam int OD_W  = 30;
	localparam int A_W   = 30;
	localparam int H_W   = 32;
	localparam int OSQ_W = 32;
	localparam int RSQ_W = 34;
	localparam int C_W   = 35;
	localparam int NP_W  = 17;
	localparam int W64   = 64;

	localparam logic [2:0] REG_CAMERA_X      = 3'd0;
	localparam logic [2:0] REG_CAMERA_Y      = 3'd1;
	localparam logic [2:0] REG_CAMERA_Z      = 3'd2;
	localparam logic [2:0] REG_SPHERE_RADIUS = 3'd3;
	localparam logic [2:0] REG_PLANE_OFFSET  = 3'd4;
	localparam logic [2:0] REG_FOCAL_DEPTH   = 3'd5;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_PLANE  = 2'd1;
	localparam logic [1:0] KIND_SPHERE = 2'd2;

	localparam logic [7:0] PLANE_GREY = 8'd204;
	localparam logic [7:0] CH_FULL    = 8'd255;
	localparam logic [7:0] CH_ZERO    = 8'd0;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [1:0] hit_kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} result_t;

	typedef struct packed {
		logic [15:0] camera_x;
		logic [15:0] camera_y;
		logic [15:0] camera_z;
		logic [15:0] sphere_radius;
		logic [15:0] plane_offset;
		logic [11:0] focal_depth;
	} cfg_t;

	typedef struct packed {
		logic                  valid;
		logic [A_W-1:0]        a;
		logic [H_W-1:0]        h;
		logic [C_W-1:0]        c;
		logic [NP_W-1:0]       np;
		logic [NP_W-1:0]       pn;
		logic [D_W-1:0]        dy;
		logic [D_W-1:0]        mag;
		logic                  plane_ok;
	} ray_t;

endpackage

// ===== hw/rtl/prpsc_cfg.sv =====
`timescale 1ns / 1ps
module prpsc_cfg import prpsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_x      <= 16'd0;
			cfg_q.camera_y      <= 16'd128;
			cfg_q.camera_z      <= 16'hFE80;
			cfg_q.sphere_radius <= 16'd256;
			cfg_q.plane_offset  <= 16'd0;
			cfg_q.focal_depth   <= 12'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAMERA_X:      cfg_q.camera_x      <= cfg_data;
				REG_CAMERA_Y:      cfg_q.camera_y      <= cfg_data;
				REG_CAMERA_Z:      cfg_q.camera_z      <= cfg_data;
				REG_SPHERE_RADIUS: cfg_q.sphere_radius <= cfg_data;
				REG_PLANE_OFFSET:  cfg_q.plane_offset  <= cfg_data;
				REG_FOCAL_DEPTH:   cfg_q.focal_depth   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/prpsc_ray.sv =====
`timescale 1ns / 1ps
module prpsc_ray import prpsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  pixel_t pixel,
	input  cfg_t   cfg,
	output ray_t   ray
);

	logic signed [15:0] ox, oy, oz, po;
	logic signed [16:0] rad;
	assign ox  = $signed(cfg.camera_x);
	assign oy  = $signed(cfg.camera_y);
	assign oz  = $signed(cfg.camera_z);
	assign po  = $signed(cfg.plane_offset);
	assign rad = $signed({1'b0, cfg.sphere_radius});

	logic signed [D_W-1:0] px2, py2;
	assign px2 = $signed({{(D_W-PIX_W-1){1'b0}}, pixel.pixel_x, 1'b0});
	assign py2 = $signed({{(D_W-PIX_W-1){1'b0}}, pixel.pixel_y, 1'b0});

	logic                   v_s1, v_s2, v_s3;
	logic signed [D_W-1:0]  dx_s1, dy_s1, dz_s1;
	logic signed [NP_W-1:0] np_s1;

	logic signed [SQ_W-1:0]  dx2_s2, dy2_s2, dz2_s2;
	logic signed [OD_W-1:0]  oxdx_s2, oydy_s2, ozdz_s2;
	logic signed [OSQ_W-1:0] ox2_s2, oy2_s2, oz2_s2;
	logic signed [RSQ_W-1:0] r2_s2;
	logic signed [NP_W-1:0]  np_s2;
	logic signed [D_W-1:0]   dy_s2;

	logic signed [A_W-1:0]  a_s3;
	logic signed [H_W-1:0]  h_s3;
	logic signed [C_W-1:0]  c_s3;
	logic signed [NP_W-1:0] np_s3, pn_s3;
	logic signed [D_W-1:0]  dy_s3, mag_s3;
	logic                   pok_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= px2 - D_W'(SCREEN_W);
		dy_s1 <= D_W'(SCREEN_H) - py2;
		dz_s1 <= $signed({1'b0, cfg.focal_depth, 1'b0});
		np_s1 <= NP_W'(po) - NP_W'(oy);

		dx2_s2  <= dx_s1 * dx_s1;
		dy2_s2  <= dy_s1 * dy_s1;
		dz2_s2  <= dz_s1 * dz_s1;
		oxdx_s2 <= ox * dx_s1;
		oydy_s2 <= oy * dy_s1;
		ozdz_s2 <= oz * dz_s1;
		ox2_s2  <= ox * ox;
		oy2_s2  <= oy * oy;
		oz2_s2  <= oz * oz;
		r2_s2   <= rad * rad;
		np_s2   <= np_s1;
		dy_s2   <= dy_s1;

		a_s3   <= A_W'(dx2_s2) + A_W'(dy2_s2) + A_W'(dz2_s2);
		h_s3   <= H_W'(oxdx_s2) + H_W'(oydy_s2) + H_W'(ozdz_s2);
		c_s3   <= C_W'(ox2_s2) + C_W'(oy2_s2) + C_W'(oz2_s2) - C_W'(r2_s2);
		np_s3  <= np_s2;
		dy_s3  <= dy_s2;
		mag_s3 <= dy_s2[D_W-1] ? -dy_s2 : dy_s2;
		pn_s3  <= dy_s2[D_W-1] ? -np_s2 : np_s2;
		pok_s3 <= (dy_s2 != '0) && ((dy_s2[D_W-1] ? -np_s2 : np_s2) >= 0);
	end

	always_comb begin
		ray.valid    = v_s3;
		ray.a        = a_s3;
		ray.h        = h_s3;
		ray.c        = c_s3;
		ray.np       = np_s3;
		ray.pn       = pn_s3;
		ray.dy       = dy_s3;
		ray.mag      = mag_s3;
		ray.plane_ok = pok_s3;
	end

endmodule

// ===== hw/rtl/prpsc_hit.sv =====
`timescale 1ns / 1ps
module prpsc_hit import prpsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  ray_t    ray,
	output logic    done,
	output result_t result
);

	logic signed [A_W-1:0]  a;
	logic signed [H_W-1:0]  h;
	logic signed [C_W-1:0]  c;
	logic signed [NP_W-1:0] np, pn;
	logic signed [D_W-1:0]  dy, mag;
	assign a   = $signed(ray.a);
	assign h   = $signed(ray.h);
	assign c   = $signed(ray.c);
	assign np  = $signed(ray.np);
	assign pn  = $signed(ray.pn);
	assign dy  = $signed(ray.dy);
	assign mag = $signed(ray.mag);

	logic                v_s4, v_s5, v_s6;
	logic signed [W64-1:0] hh_s4, ac_s4;
	logic signed [33:0]  np2_s4;
	logic signed [48:0]  hnp_s4;
	logic signed [27:0]  dy2_s4;
	logic signed [46:0]  pna_s4;
	logic signed [45:0]  hmag_s4;
	logic signed [A_W-1:0] a_s4;
	logic signed [C_W-1:0] c_s4;
	logic signed [D_W-1:0] dy_s4;
	logic                near_s4, far_s4, pok_s4;

	logic signed [W64-1:0] anp2_s5, hnpdy_s5, cdy2_s5;
	logic                disc_pos_s5, rv_pos_s5, near_s5, far_s5, pok_s5;

	result_t             res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= ray.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		hh_s4   <= h * h;
		ac_s4   <= a * c;
		np2_s4  <= np * np;
		hnp_s4  <= h * np;
		dy2_s4  <= dy * dy;
		pna_s4  <= pn * a;
		hmag_s4 <= h * mag;
		a_s4    <= a;
		c_s4    <= c;
		dy_s4   <= dy;
		near_s4 <= (h <= 0) && (c >= 0);
		far_s4  <= (h <= 0) || (c <= 0);
		pok_s4  <= ray.plane_ok;
	end

	logic signed [W64-1:0] disc;
	logic signed [47:0]    rv;
	assign disc = hh_s4 - ac_s4;
	assign rv   = 48'(pna_s4) + 48'(hmag_s4);

	always_ff @(posedge clk) begin
		anp2_s5     <= a_s4 * np2_s4;
		hnpdy_s5    <= hnp_s4 * dy_s4;
		cdy2_s5     <= c_s4 * dy2_s4;
		disc_pos_s5 <= disc > 0;
		rv_pos_s5   <= rv > 0;
		near_s5     <= near_s4;
		far_s5      <= far_s4;
		pok_s5      <= pok_s4;
	end

	logic signed [W64-1:0] g;
	logic                  sph_ok, sph_first;
	logic [1:0]            kind;

	always_comb begin
		g         = anp2_s5 + (hnpdy_s5 <<< 1) + cdy2_s5;
		sph_ok    = disc_pos_s5 && far_s5;
		sph_first = near_s5 ? ((g < 0) || rv_pos_s5) : ((g > 0) && rv_pos_s5);
		if (pok_s5 && sph_ok)
			kind = sph_first ? KIND_SPHERE : KIND_PLANE;
		else if (pok_s5)
			kind = KIND_PLANE;
		else if (sph_ok)
			kind = KIND_SPHERE;
		else
			kind = KIND_NONE;
	end

	always_ff @(posedge clk) begin
		res_s6.hit_kind <= kind;
		case (kind)
			KIND_PLANE: begin
				res_s6.red   <= PLANE_GREY;
				res_s6.green <= PLANE_GREY;
				res_s6.blue  <= PLANE_GREY;
			end
			KIND_SPHERE: begin
				res_s6.red   <= CH_FULL;
				res_s6.green <= CH_ZERO;
				res_s6.blue  <= CH_ZERO;
			end
			default: begin
				res_s6.red   <= CH_ZERO;
				res_s6.green <= CH_ZERO;
				res_s6.blue  <= CH_ZERO;
			end
		endcase
	end

	assign done   = v_s6;
	assign result = res_s6;

endmodule

// ===== hw/rtl/pixel_ray_plane_sphere_cast.sv =====
`timescale 1ns / 1ps
// Casts one primary ray per pixel against a horizontal plane and an origin-centred sphere
// and returns the hit kind and colour. A pixel is taken on every clock with start high; busy
// never rises. Each result appears with done once the pixel has passed the six-stage
// pipeline, one result per cycle at full rate. The receiver cannot stall
// the output, so take each result word in the cycle done is high. Write configuration only
// while no pixel is in flight.
module pixel_ray_plane_sphere_cast import prpsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pixel_t      pixel,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg;
	ray_t ray;

	assign busy = 1'b0;

	prpsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	prpsc_ray u_ray (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.pixel    (pixel),
		.cfg      (cfg),
		.ray      (ray)
	);

	prpsc_hit u_hit (
		.clk    (clk),
		.arst_n (arst_n),
		.ray    (ray),
		.done   (done),
		.result (result)
	);

endmodule

// ===== hw/rtl/prpsc_checker.sv =====
`timescale 1ns / 1ps
module prpsc_checker import prpsc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("word not delivered six cycles after accept");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##6 !done)
		else $error("result word without accepted pixel");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hit_kind == KIND_NONE || result.hit_kind == KIND_PLANE ||
			result.hit_kind == KIND_SPHERE))
		else $error("bad hit kind");

	a_color: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit_kind == KIND_SPHERE) |->
			(result.red == CH_FULL && result.green == CH_ZERO && result.blue == CH_ZERO))
		else $error("sphere color mismatch");

endmodule

bind pixel_ray_plane_sphere_cast prpsc_checker u_prpsc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import prpsc_pkg::*;

	localparam int LATENCY = 6;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	pixel_t      pixel;
	logic        done;
	result_t     result;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	pixel_t  pixel_queue[$];
	result_t pending_colors[$];

	logic [15:0] cam_x, cam_y, cam_z, radius, plane_y;
	logic [11:0] depth;

	int  mismatches;
	bit  calm;
	bit  stim_done;

	pixel_ray_plane_sphere_cast DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic result_t cast_pixel(pixel_t p);
		longint dx, dy, dz, ox, oy, oz, rad, a, h, c, np, mag, pn, disc, g, rv;
		bit plane_ok, near_ok, far_ok, sphere_ok, sphere_first;
		result_t r;
		dx = 2 * longint'(p.pixel_x) - SCREEN_W;
		dy = SCREEN_H - 2 * longint'(p.pixel_y);
		dz = 2 * longint'(depth);
		ox = longint'($signed(cam_x));
		oy = longint'($signed(cam_y));
		oz = longint'($signed(cam_z));
		rad = longint'(radius);
		a = dx * dx + dy * dy + dz * dz;
		h = ox * dx + oy * dy + oz * dz;
		c = ox * ox + oy * oy + oz * oz - rad * rad;
		np = longint'($signed(plane_y)) - oy;
		mag = dy < 0 ? -dy : dy;
		pn = dy < 0 ? -np : np;
		plane_ok = (dy != 0) && (pn >= 0);
		disc = h * h - a * c;
		near_ok = (h <= 0) && (c >= 0);
		far_ok = (h <= 0) || (c <= 0);
		sphere_ok = (disc > 0) && far_ok;
		r.hit_kind = KIND_NONE;
		if (plane_ok && sphere_ok) begin
			g = a * np * np + 2 * h * np * dy + c * dy * dy;
			rv = pn * a + h * mag;
			if (near_ok)
				sphere_first = (g < 0) || (rv > 0);
			else
				sphere_first = (g > 0) && (rv > 0);
			r.hit_kind = sphere_first ? KIND_SPHERE : KIND_PLANE;
		end else if (plane_ok) begin
			r.hit_kind = KIND_PLANE;
		end else if (sphere_ok) begin
			r.hit_kind = KIND_SPHERE;
		end
		case (r.hit_kind)
			KIND_PLANE: begin
				r.red = PLANE_GREY; r.green = PLANE_GREY; r.blue = PLANE_GREY;
			end
			KIND_SPHERE: begin
				r.red = CH_FULL; r.green = CH_ZERO; r.blue = CH_ZERO;
			end
			default: begin
				r.red = CH_ZERO; r.green = CH_ZERO; r.blue = CH_ZERO;
			end
		endcase
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n && !cfg_we && pixel_queue.size() > 0 && (calm || $urandom_range(99) >= 29))
		begin
			start <= 1'b1;
			pixel <= pixel_queue[0];
		end else begin
			start <= 1'b0;
			pixel <= pixel_t'($urandom);
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && start && !busy) begin
			pending_colors.push_back(cast_pixel(pixel));
			void'(pixel_queue.pop_front());
		end
		if (arst_n && done) begin
			if (pending_colors.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %p", result);
			end else begin
				want = pending_colors.pop_front();
				if (result.hit_kind !== want.hit_kind || result.red !== want.red ||
				    result.green !== want.green || result.blue !== want.blue) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, result);
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CAMERA_X:      cam_x = val;
			REG_CAMERA_Y:      cam_y = val;
			REG_CAMERA_Z:      cam_z = val;
			REG_SPHERE_RADIUS: radius = val;
			REG_PLANE_OFFSET:  plane_y = val;
			REG_FOCAL_DEPTH:   depth = val[11:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pixel_queue.size() > 0 || pending_colors.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.pixel_x = PIX_W'($urandom_range(3) == 0 ? $urandom_range(511) :
			$urandom_range(150, 360));
		p.pixel_y = PIX_W'($urandom_range(3) == 0 ? $urandom_range(511) :
			$urandom_range(150, 360));
		return p;
	endfunction

	task automatic push_pixel(int x, int y);
		pixel_t p;
		p.pixel_x = PIX_W'(x);
		p.pixel_y = PIX_W'(y);
		pixel_queue.push_back(p);
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cam_x = 16'd0; cam_y = 16'd128; cam_z = 16'hFE80;
		radius = 16'd256; plane_y = 16'd0; depth = 12'd100;
		mismatches = 0;
		calm = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corners, centre, horizon row and rows near it
		push_pixel(0, 0); push_pixel(511, 511); push_pixel(0, 511); push_pixel(511, 0);
		push_pixel(256, 256); push_pixel(256, 300); push_pixel(256, 200);
		push_pixel(100, 256); push_pixel(300, 270); push_pixel(256, 230);
		drain();
		// camera on the plane, unused index, then camera inside sphere
		write_reg(REG_CAMERA_Y, 16'd0);
		write_reg(3'd6, 16'hFFFF);
		write_reg(3'd7, 16'h1234);
		push_pixel(256, 300); push_pixel(256, 200); push_pixel(200, 256); push_pixel(511, 0);
		drain();
		write_reg(REG_CAMERA_Z, 16'd0);
		write_reg(REG_CAMERA_Y, 16'd64);
		push_pixel(256, 300); push_pixel(256, 100); push_pixel(0, 0);
		drain();
		// grazing: camera z -1024, radius 256, ray tangent via x offset camera
		write_reg(REG_CAMERA_X, 16'd256);
		write_reg(REG_CAMERA_Y, 16'd0);
		write_reg(REG_CAMERA_Z, 16'hFC00);
		write_reg(REG_PLANE_OFFSET, 16'h8000);
		push_pixel(256, 256); push_pixel(256, 300); push_pixel(260, 250);
		drain();
		// zero focal depth via 16-bit write, extremes
		write_reg(REG_FOCAL_DEPTH, 16'hF000);
		write_reg(REG_CAMERA_X, 16'd0);
		push_pixel(256, 256); push_pixel(0, 256); push_pixel(256, 511);
		drain();

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_CAMERA_X, 16'd0); write_reg(REG_CAMERA_Y, 16'd128);
					write_reg(REG_CAMERA_Z, 16'hFE80); write_reg(REG_SPHERE_RADIUS, 16'd256);
					write_reg(REG_PLANE_OFFSET, 16'd0); write_reg(REG_FOCAL_DEPTH, 16'd100);
				end
				1: begin
					write_reg(REG_CAMERA_X, 16'h7FFF); write_reg(REG_CAMERA_Y, 16'h8000);
					write_reg(REG_CAMERA_Z, 16'h7FFF); write_reg(REG_SPHERE_RADIUS, 16'hFFFF);
					write_reg(REG_PLANE_OFFSET, 16'h7FFF); write_reg(REG_FOCAL_DEPTH, 16'd4095);
				end
				2: begin
					write_reg(REG_CAMERA_X, 16'h8000); write_reg(REG_CAMERA_Y, 16'h7FFF);
					write_reg(REG_CAMERA_Z, 16'h8000); write_reg(REG_SPHERE_RADIUS, 16'd0);
					write_reg(REG_PLANE_OFFSET, 16'h8000); write_reg(REG_FOCAL_DEPTH, 16'd1);
				end
				default: begin
					write_reg(REG_CAMERA_X, 16'($signed($urandom_range(0, 1024)) - 512));
					write_reg(REG_CAMERA_Y, 16'($signed($urandom_range(0, 1024)) - 512));
					write_reg(REG_CAMERA_Z, 16'($signed($urandom_range(0, 2048)) - 2048));
					write_reg(REG_SPHERE_RADIUS, 16'($urandom_range(0, 1024)));
					write_reg(REG_PLANE_OFFSET, 16'($signed($urandom_range(0, 512)) - 384));
					write_reg(REG_FOCAL_DEPTH, 16'($urandom));
				end
			endcase
			calm = (phase == 4);
			n = 200;
			for (int i = 0; i < n; i++)
				pixel_queue.push_back(rand_pixel());
			drain();
		end

		if (mismatches == 0)
			$display("pixel_ray_plane_sphere_cast test passed");
		else
			$display("pixel_ray_plane_sphere_cast test failed");
		$finish;
	end

	initial begin
		#200000;
		$display("pixel_ray_plane_sphere_cast test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/prpsc_pkg.sv
hw/rtl/prpsc_cfg.sv
hw/rtl/prpsc_ray.sv
hw/rtl/prpsc_hit.sv
hw/rtl/pixel_ray_plane_sphere_cast.sv
hw/rtl/prpsc_checker.sv
dv/testbench.sv
